[sv/lpcd_pkg.sv]
// lpcd_pkg: shared types and status codes of the length prefixed chunk deframer
// used by lpcd_step, lpcd_rsp_fifo and the top level; no dependencies

package lpcd_pkg;

   // chunk status codes
   localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_TRUNC   = 2'd2;

   // response fifo geometry
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       chunk_end;
      logic [1:0] chunk_status;
   } rsp_type;

   // everything one accepted byte produces: up to two response words
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rsp0;
      rsp_type    rsp1;
   } step_out_type;

endpackage

[sv/lpcd_step.sv]
// lpcd_step: deframer state machine, one input byte per cycle while in_accept is high
// emits up to two response words per byte; depends on lpcd_pkg

module lpcd_step import lpcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_accept,
   input  logic [7:0]   in_byte,
   input  logic         buffer_first,
   input  logic         buffer_last,
   output step_out_type step_out
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_HDR2    = 4'd1;
   localparam logic [3:0] PH_PASS    = 4'd2;
   localparam logic [3:0] PH_LEN     = 4'd3;
   localparam logic [3:0] PH_FF1     = 4'd4;
   localparam logic [3:0] PH_FF2     = 4'd5;
   localparam logic [3:0] PH_PREFIX  = 4'd6;
   localparam logic [3:0] PH_PAYLOAD = 4'd7;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] length_acc_ff, length_acc_in;
   logic [2:0]  prefix_left_ff, prefix_left_in;

   logic [1:0]  n;
   rsp_type     res [2];
   logic        inside_chunk;
   logic        idle_drop;

   function automatic rsp_type make_rsp(logic [7:0] b, logic e, logic [1:0] s);
      rsp_type r;
      r.payload_byte = b;
      r.chunk_end    = e;
      r.chunk_status = s;
      return r;
   endfunction

   assign inside_chunk = (phase_ff == PH_HDR2) || (phase_ff == PH_PASS) ||
                         (phase_ff == PH_FF1) || (phase_ff == PH_FF2) ||
                         (phase_ff == PH_PREFIX) || (phase_ff == PH_PAYLOAD);

   always_comb begin
      phase_in       = phase_ff;
      held_byte_in   = held_byte_ff;
      remaining_in   = remaining_ff;
      length_acc_in  = length_acc_ff;
      prefix_left_in = prefix_left_ff;
      n              = 2'd0;
      res[0]         = make_rsp(8'h00, 1'b0, STATUS_PAYLOAD);
      res[1]         = make_rsp(8'h00, 1'b0, STATUS_PAYLOAD);
      idle_drop      = 1'b0;

      if (buffer_first) begin
         if (inside_chunk) begin
            res[n[0]] = make_rsp(8'h00, 1'b1, STATUS_TRUNC);
            n = n + 2'd1;
         end
         if (in_byte == 8'h00) begin
            held_byte_in = in_byte;
            phase_in     = PH_HDR2;
         end else begin
            res[n[0]] = make_rsp(in_byte, 1'b0, STATUS_PAYLOAD);
            n = n + 2'd1;
            phase_in = PH_PASS;
         end
      end else begin
         unique case (phase_ff)
            PH_HDR2: begin
               if (in_byte == 8'h19) begin
                  phase_in = PH_LEN;
               end else begin
                  res[0]   = make_rsp(held_byte_ff, 1'b0, STATUS_PAYLOAD);
                  res[1]   = make_rsp(in_byte, 1'b0, STATUS_PAYLOAD);
                  n        = 2'd2;
                  phase_in = PH_PASS;
               end
            end
            PH_PASS: begin
               res[0] = make_rsp(in_byte, 1'b0, STATUS_PAYLOAD);
               n      = 2'd1;
            end
            PH_LEN: begin
               if (in_byte == 8'h00) begin
                  res[0] = make_rsp(8'h00, 1'b1, STATUS_EMPTY);
                  n      = 2'd1;
               end else if (in_byte != 8'hff) begin
                  remaining_in = {24'd0, in_byte};
                  phase_in     = PH_PAYLOAD;
               end else begin
                  phase_in = PH_FF1;
               end
            end
            PH_FF1: begin
               if (in_byte == 8'h00) begin
                  // 0xff 0x00: length 255, the zero is the first payload byte
                  res[0]       = make_rsp(8'h00, 1'b0, STATUS_PAYLOAD);
                  n            = 2'd1;
                  remaining_in = 32'd254;
                  phase_in     = PH_PAYLOAD;
               end else if (in_byte == 8'hff) begin
                  phase_in = PH_FF2;
               end else begin
                  length_acc_in  = 32'd0;
                  prefix_left_in = 3'd2;
                  phase_in       = PH_PREFIX;
               end
            end
            PH_FF2: begin
               length_acc_in  = 32'd0;
               prefix_left_in = (in_byte != 8'h00) ? 3'd4 : 3'd1;
               phase_in       = PH_PREFIX;
            end
            PH_PREFIX: begin
               length_acc_in  = {length_acc_ff[23:0], in_byte};
               prefix_left_in = (prefix_left_ff != 3'd0) ? prefix_left_ff - 3'd1 : 3'd0;
               if (prefix_left_in == 3'd0) begin
                  if (length_acc_in == 32'd0) begin
                     res[0]   = make_rsp(8'h00, 1'b1, STATUS_EMPTY);
                     n        = 2'd1;
                     phase_in = PH_LEN;
                  end else begin
                     remaining_in = length_acc_in;
                     phase_in     = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               remaining_in = (remaining_ff != 32'd0) ? remaining_ff - 32'd1 : 32'd0;
               res[0] = make_rsp(in_byte, remaining_in == 32'd0, STATUS_PAYLOAD);
               n      = 2'd1;
               if (remaining_in == 32'd0) begin
                  phase_in = PH_LEN;
               end
            end
            default: begin
               // no buffer open: the byte is dropped
               idle_drop = 1'b1;
            end
         endcase
      end

      if (buffer_last && !idle_drop) begin
         if (phase_in == PH_HDR2) begin
            res[n[0]] = make_rsp(held_byte_in, 1'b1, STATUS_PAYLOAD);
            n = n + 2'd1;
         end else if (phase_in == PH_PASS) begin
            if (n != 2'd0) begin
               res[1'(n - 2'd1)].chunk_end = 1'b1;
            end
         end else if ((phase_in == PH_FF1) || (phase_in == PH_FF2) ||
                      (phase_in == PH_PREFIX) || (phase_in == PH_PAYLOAD)) begin
            res[n[0]] = make_rsp(8'h00, 1'b1, STATUS_TRUNC);
            n = n + 2'd1;
         end
         phase_in = PH_IDLE;
      end
   end

   assign step_out.count = in_accept ? n : 2'd0;
   assign step_out.rsp0  = res[0];
   assign step_out.rsp1  = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         held_byte_ff   <= 8'h00;
         remaining_ff   <= 32'd0;
         length_acc_ff  <= 32'd0;
         prefix_left_ff <= 3'd0;
      end else if (in_accept) begin
         phase_ff       <= phase_in;
         held_byte_ff   <= held_byte_in;
         remaining_ff   <= remaining_in;
         length_acc_ff  <= length_acc_in;
         prefix_left_ff <= prefix_left_in;
      end
   end

`ifndef ASSERT_OFF
   // phase never leaves the defined codes' range
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_PAYLOAD)
      else $error("lpcd_step: phase out of range");

   // a payload phase always has bytes still due
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != 32'd0))
      else $error("lpcd_step: payload phase with zero remaining");

   // status words are always chunk ends with a zero byte
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      (step_out.count != 2'd0 && step_out.rsp0.chunk_status != STATUS_PAYLOAD) |->
      (step_out.rsp0.chunk_end && step_out.rsp0.payload_byte == 8'h00))
      else $error("lpcd_step: malformed status word");
`endif

endmodule

[sv/lpcd_rsp_fifo.sv]
// lpcd_rsp_fifo: four-word response queue, up to two pushes and one pop per cycle
// decouples the deframer from output stalls; depends on lpcd_pkg

module lpcd_rsp_fifo import lpcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  step_out_type push,
   input  logic         pop,
   output logic         room,
   output logic         head_valid,
   output rsp_type      head
);

   rsp_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   // two free words are always kept for the worst-case byte
   assign room       = (count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(do_pop);
   assign count_in  = count_ff + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.rsp0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + FIFO_AW'(1)] <= push.rsp1;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("lpcd_rsp_fifo: push without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH))
      else $error("lpcd_rsp_fifo: fill count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[FIFO_AW-1:0])
      else $error("lpcd_rsp_fifo: pointers disagree with fill count");
`endif

endmodule

[sv/length_prefixed_chunk_deframer.sv]
// length_prefixed_chunk_deframer: splits length-prefixed buffers into chunk payload words
// output: response words are registered in the queue and shown from its head in order
// throughput: one byte per cycle while the queue has room; a byte giving two words
// pops them singly; the four-word queue takes a byte only while two words are free in it
// reset: synchronous active-high reset empties the queue and returns to waiting for a buffer
// depends on lpcd_pkg, lpcd_step, lpcd_rsp_fifo

module length_prefixed_chunk_deframer import lpcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request stream: one buffer byte per word
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] buffer_first
   input  logic       req_tlast,   // buffer_last
   // response stream: payload bytes and chunk status words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [1:0] rsp_tuser,   // [1:0] chunk_status
   output logic       rsp_tlast    // chunk_end
);

   step_out_type step_out;
   rsp_type      head;
   logic         room;
   logic         req_accept;

   // a byte is taken whenever the queue can absorb its worst case of two words
   assign req_tready = room;
   assign req_accept = req_tvalid && req_tready;

   // header detection, length prefix decode and payload counting
   lpcd_step u_step (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (req_accept),
      .in_byte      (req_tdata),
      .buffer_first (req_tuser),
      .buffer_last  (req_tlast),
      .step_out     (step_out)
   );

   // response queue doubles as the output register
   lpcd_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (step_out),
      .pop        (rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = head.payload_byte;
   assign rsp_tlast = head.chunk_end;
   assign rsp_tuser = head.chunk_status;

endmodule
